>>> rtl/ppf_pkg.sv
package ppf_pkg;

	// Rule table depth (number of cells in the chain)
	localparam int unsigned RULE_ENTRIES = 128;
	localparam int unsigned FILL_W = $clog2(RULE_ENTRIES + 1);

	// Configuration port
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_APP_UID_MIN    = 3'd0,
		CFG_TRACKER_A      = 3'd1,
		CFG_TRACKER_B      = 3'd2,
		CFG_TRACKER_C      = 3'd3,
		CFG_TRACKER_ENABLE = 3'd4
	} cfg_idx_t;

	// Register reset values
	localparam logic [31:0] APP_UID_MIN_RST    = 32'd10000;
	localparam logic [15:0] TRACKER_A_RST      = 16'hD8EF;
	localparam logic [15:0] TRACKER_B_RST      = 16'h9DF0;
	localparam logic [15:0] TRACKER_C_RST      = 16'h4A7D;
	localparam logic [2:0]  TRACKER_ENABLE_RST = 3'b111;

	typedef enum logic {
		OP_PACKET = 1'b0,
		OP_RULE   = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		CAUSE_OK      = 2'd0,
		CAUSE_PERM    = 2'd1,
		CAUSE_TRACKER = 2'd2
	} cause_t;

	// Input word
	typedef struct packed {
		opcode_t     opcode;
		logic        has_socket;
		logic [31:0] user_id;
		logic [31:0] dest_addr;
		logic        permit_network;
		logic        enforce_trackers;
	} in_word_t;

	// Result word
	typedef struct packed {
		logic        drop;
		cause_t      cause;
		logic        event_logged;
		logic        table_full;
		logic [31:0] seen_count;
		logic [31:0] blocked_count;
		logic [31:0] tracker_count;
		logic [7:0]  rules_in_use;
	} out_word_t;

	// Word as it walks the cell chain
	typedef struct packed {
		logic        vld;
		opcode_t     opcode;
		logic        has_socket;
		logic [31:0] user_id;
		logic        permit;       // rule value carried by a rule word
		logic        app;          // user id at or above app minimum
		logic        trk;          // destination hits an enabled tracker prefix
		logic        found;        // a cell already holds this user
		logic        rule_permit;  // permit flag of the matching cell
		logic        stored;       // appended into a free cell
	} item_t;

endpackage

>>> rtl/per_user_packet_filter.sv
// Channel | signals                        | direction | word
// --------+--------------------------------+-----------+--------------------
// pkt     | pkt_valid, pkt_stall, pkt      | in        | ppf_pkg::in_word_t
// res     | res_valid, res_stall, res      | out       | ppf_pkg::out_word_t
// cfg     | cfg_we, cfg_index, cfg_data    | in        | register write
//
// One word enters per cycle while the chain moves; each result is registered
// by the tail after the word walks the rule cells, one cell per cycle.
// Reset clears the counters and all fill flags, and loads config reset values.
// A stalled result holds the whole chain; pkt_stall follows res_stall then.
module per_user_packet_filter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pkt_valid,
	output logic                               pkt_stall,
	input  ppf_pkg::in_word_t                  pkt,
	output logic                               res_valid,
	input  logic                               res_stall,
	output ppf_pkg::out_word_t                 res,
	input  logic                               cfg_we,
	input  logic [ppf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ppf_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [31:0] app_uid_min_q;
	logic [15:0] tracker_a_q;
	logic [15:0] tracker_b_q;
	logic [15:0] tracker_c_q;
	logic [2:0]  tracker_en_q;

	logic           adv;
	logic [15:0]    top16;
	ppf_pkg::item_t head;
	ppf_pkg::item_t chain [ppf_pkg::RULE_ENTRIES+1];

	// the chain moves whenever the result slot is free or being taken
	assign adv       = !res_valid || !res_stall;
	assign pkt_stall = !adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			app_uid_min_q <= ppf_pkg::APP_UID_MIN_RST;
			tracker_a_q   <= ppf_pkg::TRACKER_A_RST;
			tracker_b_q   <= ppf_pkg::TRACKER_B_RST;
			tracker_c_q   <= ppf_pkg::TRACKER_C_RST;
			tracker_en_q  <= ppf_pkg::TRACKER_ENABLE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ppf_pkg::CFG_APP_UID_MIN:    app_uid_min_q <= cfg_data;
				ppf_pkg::CFG_TRACKER_A:      tracker_a_q   <= cfg_data[15:0];
				ppf_pkg::CFG_TRACKER_B:      tracker_b_q   <= cfg_data[15:0];
				ppf_pkg::CFG_TRACKER_C:      tracker_c_q   <= cfg_data[15:0];
				ppf_pkg::CFG_TRACKER_ENABLE: tracker_en_q  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// entry: classify user and destination, seed the chain word
	assign top16 = pkt.dest_addr[31:16];

	always_comb begin
		head.vld         = pkt_valid;
		head.opcode      = pkt.opcode;
		head.has_socket  = pkt.has_socket;
		head.user_id     = pkt.user_id;
		head.permit      = pkt.permit_network;
		head.app         = pkt.user_id >= app_uid_min_q;
		head.trk         = (tracker_en_q[0] && top16 == tracker_a_q)
			|| (tracker_en_q[1] && top16 == tracker_b_q)
			|| (tracker_en_q[2] && top16 == tracker_c_q);
		head.found       = 1'b0;
		head.rule_permit = 1'b0;
		head.stored      = 1'b0;
	end

	assign chain[0] = head;

	// rule cells; the tracker flag of a rule never affects a verdict
	for (genvar i = 0; i < ppf_pkg::RULE_ENTRIES; i++) begin : g_cell
		ppf_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.item_d (chain[i]),
			.item_q (chain[i+1])
		);
	end

	ppf_tail u_tail (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.item      (chain[ppf_pkg::RULE_ENTRIES]),
		.res_valid (res_valid),
		.res       (res)
	);

endmodule

>>> rtl/ppf_cell.sv
// One rule entry. The word passes through the item_q register; matches and
// appends happen as it goes by, so later words see the update.
module ppf_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  ppf_pkg::item_t item_d,
	output ppf_pkg::item_t item_q
);

	logic        used_q;
	logic [31:0] user_q;
	logic        permit_q;

	logic           hit;
	logic           claim;
	ppf_pkg::item_t item_nxt;

	// match against this entry, or take it when it is the first free one
	assign hit   = item_d.vld && used_q && (user_q == item_d.user_id);
	assign claim = item_d.vld && (item_d.opcode == ppf_pkg::OP_RULE) && !used_q
		&& !item_d.found && !item_d.stored;

	always_comb begin
		item_nxt = item_d;
		if (hit) begin
			item_nxt.found       = 1'b1;
			item_nxt.rule_permit = permit_q;
		end
		if (claim) begin
			item_nxt.stored = 1'b1;
		end
	end

	// fill flag: entries fill from the head of the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (adv && claim) begin
			used_q <= 1'b1;
		end
	end

	// entry contents
	always_ff @(posedge clk) begin
		if (adv) begin
			if (claim) begin
				user_q   <= item_d.user_id;
				permit_q <= item_d.permit;
			end else if (hit && item_d.opcode == ppf_pkg::OP_RULE) begin
				permit_q <= item_d.permit;
			end
		end
	end

	// hand the word to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q <= '0;
		end else if (adv) begin
			item_q <= item_nxt;
		end
	end

endmodule

>>> rtl/ppf_tail.sv
// End of the chain: verdict, counters, fill count and the result register.
module ppf_tail (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  ppf_pkg::item_t     item,
	output logic               res_valid,
	output ppf_pkg::out_word_t res
);

	logic [31:0]               seen_q;
	logic [31:0]               blocked_q;
	logic [31:0]               tracker_q;
	logic [ppf_pkg::FILL_W-1:0] fill_q;

	ppf_pkg::out_word_t        res_nxt;
	logic [31:0]               seen_nxt;
	logic [31:0]               blocked_nxt;
	logic [31:0]               tracker_nxt;
	logic [ppf_pkg::FILL_W-1:0] fill_nxt;
	logic                      drop;
	logic                      full;
	logic                      log_ev;
	logic                      trk_hit;
	ppf_pkg::cause_t           cause;

	// verdict
	always_comb begin
		drop    = 1'b0;
		full    = 1'b0;
		log_ev  = 1'b0;
		trk_hit = 1'b0;
		cause   = ppf_pkg::CAUSE_OK;
		case (item.opcode)
			ppf_pkg::OP_RULE: begin
				full = !item.found && !item.stored;
			end
			ppf_pkg::OP_PACKET: begin
				if (item.has_socket) begin
					if (item.app) begin
						if (!item.found || !item.rule_permit) begin
							drop  = 1'b1;
							cause = ppf_pkg::CAUSE_PERM;
						end else if (item.trk) begin
							drop    = 1'b1;
							cause   = ppf_pkg::CAUSE_TRACKER;
							trk_hit = 1'b1;
						end
						log_ev = drop;
					end else if (item.trk) begin
						cause   = ppf_pkg::CAUSE_TRACKER;
						trk_hit = 1'b1;
						log_ev  = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// running totals after this word
	always_comb begin
		seen_nxt    = seen_q + ((item.opcode == ppf_pkg::OP_PACKET) ? 32'd1 : 32'd0);
		blocked_nxt = blocked_q + {31'd0, drop};
		tracker_nxt = tracker_q + {31'd0, trk_hit};
		fill_nxt    = fill_q + {{(ppf_pkg::FILL_W-1){1'b0}}, item.stored};
	end

	always_comb begin
		res_nxt.drop          = drop;
		res_nxt.cause         = cause;
		res_nxt.event_logged  = log_ev;
		res_nxt.table_full    = full;
		res_nxt.seen_count    = seen_nxt;
		res_nxt.blocked_count = blocked_nxt;
		res_nxt.tracker_count = tracker_nxt;
		res_nxt.rules_in_use  = 8'(fill_nxt);
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= '0;
			blocked_q <= '0;
			tracker_q <= '0;
			fill_q    <= '0;
		end else if (adv && item.vld) begin
			seen_q    <= seen_nxt;
			blocked_q <= blocked_nxt;
			tracker_q <= tracker_nxt;
			fill_q    <= fill_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= item.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && item.vld) begin
			res <= res_nxt;
		end
	end

	// fill count never passes the table depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= ppf_pkg::FILL_W'(ppf_pkg::RULE_ENTRIES))
		else $error("fill count beyond table depth");

	// a full report only comes with every entry in use
	a_full_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.table_full) |->
		(res.rules_in_use == 8'(ppf_pkg::RULE_ENTRIES)))
		else $error("table full reported with free entries");

	// a rule word reporting a full table never drops or logs
	a_full_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.table_full) |-> (!res.drop && !res.event_logged))
		else $error("rule result carries a packet verdict");

	// a drop always names a cause and logs an event
	a_drop_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.drop) |-> (res.cause != ppf_pkg::CAUSE_OK && res.event_logged))
		else $error("drop without cause or event");

	// an accepted result frees the slot unless a new word arrives
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && adv && !item.vld) |=> !res_valid)
		else $error("result repeated");

endmodule

>>> tb/per_user_packet_filter_tb.sv
module per_user_packet_filter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 400_000;
	localparam int unsigned UID_POOL = 160;
	localparam int unsigned PHASES = 8;
	localparam int unsigned PHASE_WORDS = 180;
	localparam int unsigned IDLE_PCT = 19;

	typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

	// One line of the directed plan: a register write or an input word
	typedef struct {
		row_kind_t            kind;
		ppf_pkg::cfg_idx_t    reg_idx;
		logic [31:0]          reg_val;
		ppf_pkg::in_word_t    word;
		bit                   typed;
		ppf_pkg::out_word_t   result;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pkt_valid = 1'b0;
	logic pkt_stall;
	ppf_pkg::in_word_t pkt = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	ppf_pkg::out_word_t res;
	logic cfg_we = 1'b0;
	logic [ppf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ppf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// Filter state as this bench tracks it
	logic [31:0] app_min = ppf_pkg::APP_UID_MIN_RST;
	logic [15:0] pfx_a = ppf_pkg::TRACKER_A_RST;
	logic [15:0] pfx_b = ppf_pkg::TRACKER_B_RST;
	logic [15:0] pfx_c = ppf_pkg::TRACKER_C_RST;
	logic [2:0]  pfx_en = ppf_pkg::TRACKER_ENABLE_RST;
	logic [31:0] rule_uid [ppf_pkg::RULE_ENTRIES];
	logic        rule_ok [ppf_pkg::RULE_ENTRIES];
	int unsigned rules_filled = 0;
	logic [31:0] pkts_seen = '0;
	logic [31:0] pkts_blocked = '0;
	logic [31:0] trk_total = '0;

	ppf_pkg::out_word_t pending_results [$];
	ppf_pkg::out_word_t want;
	row_t plan [$];
	logic [31:0] uid_pool [UID_POOL];
	int unsigned fresh_next = 0;
	bit calm = 1'b0;
	int errors = 0;
	int n_packets = 0, n_drops = 0, n_trk = 0, n_rules = 0, n_full = 0;

	per_user_packet_filter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.pkt       (pkt),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Slot of the rule for a user, -1 if none stored
	function automatic int lookup_slot(logic [31:0] uid);
		for (int i = 0; i < rules_filled; i++)
			if (rule_uid[i] == uid)
				return i;
		return -1;
	endfunction

	// Verdict and counters after one input word; updates the tracked state
	function automatic ppf_pkg::out_word_t filter_verdict(ppf_pkg::in_word_t w);
		ppf_pkg::out_word_t r;
		int slot;
		logic [15:0] top;
		bit hit;
		r = '0;
		if (w.opcode == ppf_pkg::OP_RULE) begin
			slot = lookup_slot(w.user_id);
			if (slot < 0) begin
				if (rules_filled >= ppf_pkg::RULE_ENTRIES) begin
					r.table_full = 1'b1;
				end else begin
					slot = rules_filled;
					rule_uid[slot] = w.user_id;
					rules_filled++;
				end
			end
			if (slot >= 0)
				rule_ok[slot] = w.permit_network;
		end else begin
			pkts_seen = pkts_seen + 32'd1;
			if (w.has_socket) begin
				top = w.dest_addr[31:16];
				hit = (pfx_en[0] && top == pfx_a) || (pfx_en[1] && top == pfx_b) ||
					(pfx_en[2] && top == pfx_c);
				if (w.user_id >= app_min) begin
					// app user: default deny, then the global tracker block
					slot = lookup_slot(w.user_id);
					if (slot < 0 || !rule_ok[slot]) begin
						r.drop = 1'b1;
						r.cause = ppf_pkg::CAUSE_PERM;
					end else if (hit) begin
						r.drop = 1'b1;
						r.cause = ppf_pkg::CAUSE_TRACKER;
						trk_total = trk_total + 32'd1;
					end
					if (r.drop) begin
						pkts_blocked = pkts_blocked + 32'd1;
						r.event_logged = 1'b1;
					end
				end else if (hit) begin
					// system user: count and log only
					trk_total = trk_total + 32'd1;
					r.cause = ppf_pkg::CAUSE_TRACKER;
					r.event_logged = 1'b1;
				end
			end
		end
		r.seen_count = pkts_seen;
		r.blocked_count = pkts_blocked;
		r.tracker_count = trk_total;
		r.rules_in_use = 8'(rules_filled);
		return r;
	endfunction

	function automatic ppf_pkg::in_word_t pkt_w(ppf_pkg::opcode_t op, logic sock,
		logic [31:0] uid, logic [31:0] addr, logic perm, logic enf);
		ppf_pkg::in_word_t w;
		w.opcode = op;
		w.has_socket = sock;
		w.user_id = uid;
		w.dest_addr = addr;
		w.permit_network = perm;
		w.enforce_trackers = enf;
		return w;
	endfunction

	function automatic ppf_pkg::out_word_t res_w(logic drop, ppf_pkg::cause_t cause,
		logic logged, logic full, logic [31:0] seen, logic [31:0] blocked,
		logic [31:0] trk, logic [7:0] rules);
		ppf_pkg::out_word_t r;
		r.drop = drop;
		r.cause = cause;
		r.event_logged = logged;
		r.table_full = full;
		r.seen_count = seen;
		r.blocked_count = blocked;
		r.tracker_count = trk;
		r.rules_in_use = rules;
		return r;
	endfunction

	function automatic void add_typed(ppf_pkg::in_word_t w, ppf_pkg::out_word_t r);
		row_t row;
		row.kind = ROW_WORD;
		row.reg_idx = ppf_pkg::CFG_APP_UID_MIN;
		row.reg_val = '0;
		row.word = w;
		row.typed = 1'b1;
		row.result = r;
		plan.push_back(row);
	endfunction

	function automatic void add_word(ppf_pkg::in_word_t w);
		add_typed(w, '0);
		plan[plan.size()-1].typed = 1'b0;
	endfunction

	function automatic void add_reg(ppf_pkg::cfg_idx_t idx, logic [31:0] val);
		row_t row;
		row.kind = ROW_REG;
		row.reg_idx = idx;
		row.reg_val = val;
		row.word = '0;
		row.typed = 1'b0;
		row.result = '0;
		plan.push_back(row);
	endfunction

	// Random word: rules draw from the user pool, packets also hit the app boundary
	function automatic ppf_pkg::in_word_t random_word();
		ppf_pkg::in_word_t w;
		logic [15:0] top;
		w.opcode = ($urandom_range(0, 99) < 35) ? ppf_pkg::OP_RULE : ppf_pkg::OP_PACKET;
		w.has_socket = ($urandom_range(0, 99) < 85);
		w.permit_network = 1'($urandom_range(0, 1));
		w.enforce_trackers = 1'($urandom_range(0, 1));
		w.dest_addr = $urandom;
		if ($urandom_range(0, 99) < 40) begin
			case ($urandom_range(0, 2))
				0: top = pfx_a;
				1: top = pfx_b;
				default: top = pfx_c;
			endcase
			w.dest_addr[31:16] = top;
		end
		if (w.opcode == ppf_pkg::OP_RULE) begin
			if (fresh_next < UID_POOL && $urandom_range(0, 1) == 1) begin
				w.user_id = uid_pool[fresh_next];
				fresh_next++;
			end else begin
				w.user_id = uid_pool[$urandom_range(0, UID_POOL-1)];
			end
		end else begin
			case ($urandom_range(0, 3))
				0, 1: w.user_id = uid_pool[$urandom_range(0, UID_POOL-1)];
				2: w.user_id = app_min + $urandom_range(0, 2) - 32'd1;
				default: w.user_id = $urandom;
			endcase
		end
		return w;
	endfunction

	task automatic set_reg(ppf_pkg::cfg_idx_t idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			ppf_pkg::CFG_APP_UID_MIN: app_min = val;
			ppf_pkg::CFG_TRACKER_A: pfx_a = val[15:0];
			ppf_pkg::CFG_TRACKER_B: pfx_b = val[15:0];
			ppf_pkg::CFG_TRACKER_C: pfx_c = val[15:0];
			ppf_pkg::CFG_TRACKER_ENABLE: pfx_en = val[2:0];
			default: ;
		endcase
	endtask

	// Hold off the sender until every expected result is back
	task automatic drain_results();
		pkt_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_word(ppf_pkg::in_word_t w, bit typed, ppf_pkg::out_word_t typed_res);
		ppf_pkg::out_word_t r;
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			pkt_valid <= 1'b0;
			@(posedge clk);
		end
		pkt_valid <= 1'b1;
		pkt <= w;
		@(posedge clk);
		while (pkt_stall)
			@(posedge clk);
		r = filter_verdict(w);
		pending_results.push_back(typed ? typed_res : r);
		if (w.opcode == ppf_pkg::OP_RULE) begin
			n_rules++;
			n_full += r.table_full;
		end else begin
			n_packets++;
			n_drops += r.drop;
			n_trk += (r.cause == ppf_pkg::CAUSE_TRACKER);
		end
	endtask

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got);
		if (got !== exp_v) begin
			errors++;
			$display("%0t: %s expected %0h, got %0h", $time, name, exp_v, got);
		end
	endfunction

	// Receiver stalls at random except during the calm stretch
	always @(posedge clk)
		res_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);

	// Result checker
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result word with nothing expected, got %p", $time, res);
			end else begin
				want = pending_results.pop_front();
				check_field("drop", 32'(want.drop), 32'(res.drop));
				check_field("cause", 32'(want.cause), 32'(res.cause));
				check_field("event_logged", 32'(want.event_logged), 32'(res.event_logged));
				check_field("table_full", 32'(want.table_full), 32'(res.table_full));
				check_field("seen_count", want.seen_count, res.seen_count);
				check_field("blocked_count", want.blocked_count, res.blocked_count);
				check_field("tracker_count", want.tracker_count, res.tracker_count);
				check_field("rules_in_use", 32'(want.rules_in_use), 32'(res.rules_in_use));
			end
		end
	end

	// Watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("per_user_packet_filter test failed");
		$finish;
	end

	initial begin
		bit cfg_open;
		cfg_open = 1'b0;

		for (int i = 0; i < UID_POOL; i++)
			uid_pool[i] = (i % 2 == 0) ? 32'd10000 + i : $urandom;

		// Default registers: verdicts typed in
		add_typed(pkt_w(ppf_pkg::OP_PACKET, 1'b0, 32'hFFFF_FFFF, 32'hD8EF_0000, 1'b0, 1'b0),
			res_w(1'b0, ppf_pkg::CAUSE_OK, 1'b0, 1'b0, 1, 0, 0, 0));
		add_typed(pkt_w(ppf_pkg::OP_PACKET, 1'b1, 32'd10000, 32'h0000_0000, 1'b0, 1'b0),
			res_w(1'b1, ppf_pkg::CAUSE_PERM, 1'b1, 1'b0, 2, 1, 0, 0));
		add_typed(pkt_w(ppf_pkg::OP_PACKET, 1'b1, 32'd9999, 32'hD8EF_1234, 1'b0, 1'b0),
			res_w(1'b0, ppf_pkg::CAUSE_TRACKER, 1'b1, 1'b0, 3, 1, 1, 0));
		add_typed(pkt_w(ppf_pkg::OP_PACKET, 1'b1, 32'd0, 32'h1234_5678, 1'b0, 1'b0),
			res_w(1'b0, ppf_pkg::CAUSE_OK, 1'b0, 1'b0, 4, 1, 1, 0));
		add_typed(pkt_w(ppf_pkg::OP_RULE, 1'b0, 32'd10000, 32'h0000_0000, 1'b1, 1'b0),
			res_w(1'b0, ppf_pkg::CAUSE_OK, 1'b0, 1'b0, 4, 1, 1, 1));
		add_typed(pkt_w(ppf_pkg::OP_PACKET, 1'b1, 32'd10000, 32'h9DF0_FFFF, 1'b0, 1'b0),
			res_w(1'b1, ppf_pkg::CAUSE_TRACKER, 1'b1, 1'b0, 5, 2, 2, 1));
		add_typed(pkt_w(ppf_pkg::OP_PACKET, 1'b1, 32'd10000, 32'h4A7C_0000, 1'b0, 1'b0),
			res_w(1'b0, ppf_pkg::CAUSE_OK, 1'b0, 1'b0, 6, 2, 2, 1));
		// update of an existing rule, then its user is refused
		add_typed(pkt_w(ppf_pkg::OP_RULE, 1'b1, 32'd10000, 32'hFFFF_FFFF, 1'b0, 1'b1),
			res_w(1'b0, ppf_pkg::CAUSE_OK, 1'b0, 1'b0, 6, 2, 2, 1));
		add_typed(pkt_w(ppf_pkg::OP_PACKET, 1'b1, 32'd10000, 32'h4A7D_0001, 1'b0, 1'b0),
			res_w(1'b1, ppf_pkg::CAUSE_PERM, 1'b1, 1'b0, 7, 3, 2, 1));
		add_typed(pkt_w(ppf_pkg::OP_RULE, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1),
			res_w(1'b0, ppf_pkg::CAUSE_OK, 1'b0, 1'b0, 7, 3, 2, 2));
		add_typed(pkt_w(ppf_pkg::OP_PACKET, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1),
			res_w(1'b0, ppf_pkg::CAUSE_OK, 1'b0, 1'b0, 8, 3, 2, 2));
		add_typed(pkt_w(ppf_pkg::OP_PACKET, 1'b0, 32'd10000, 32'hD8EF_0000, 1'b0, 1'b0),
			res_w(1'b0, ppf_pkg::CAUSE_OK, 1'b0, 1'b0, 9, 3, 2, 2));
		add_typed(pkt_w(ppf_pkg::OP_RULE, 1'b1, 32'd0, 32'hD8EF_0000, 1'b0, 1'b0),
			res_w(1'b0, ppf_pkg::CAUSE_OK, 1'b0, 1'b0, 9, 3, 2, 3));
		// system user with a forbidding rule is still never dropped
		add_typed(pkt_w(ppf_pkg::OP_PACKET, 1'b1, 32'd0, 32'hD8EF_ABCD, 1'b0, 1'b0),
			res_w(1'b0, ppf_pkg::CAUSE_TRACKER, 1'b1, 1'b0, 10, 3, 3, 3));
		add_typed(pkt_w(ppf_pkg::OP_PACKET, 1'b1, 32'd10001, 32'h0000_0000, 1'b0, 1'b0),
			res_w(1'b1, ppf_pkg::CAUSE_PERM, 1'b1, 1'b0, 11, 4, 3, 3));

		// Register extremes, checked by the predictor
		add_reg(ppf_pkg::CFG_TRACKER_ENABLE, 32'd0);
		add_word(pkt_w(ppf_pkg::OP_PACKET, 1'b1, 32'd9999, 32'hD8EF_0000, 1'b0, 1'b0));
		add_word(pkt_w(ppf_pkg::OP_PACKET, 1'b1, 32'hFFFF_FFFF, 32'h9DF0_0000, 1'b0, 1'b0));
		add_reg(ppf_pkg::CFG_APP_UID_MIN, 32'd0);
		add_word(pkt_w(ppf_pkg::OP_PACKET, 1'b1, 32'd0, 32'h0000_0000, 1'b0, 1'b0));
		add_reg(ppf_pkg::CFG_APP_UID_MIN, 32'hFFFF_FFFF);
		add_word(pkt_w(ppf_pkg::OP_PACKET, 1'b1, 32'hFFFF_FFFE, 32'h0000_0000, 1'b0, 1'b0));
		add_reg(ppf_pkg::CFG_TRACKER_A, 32'h0000_FFFF);
		add_reg(ppf_pkg::CFG_TRACKER_B, 32'h0000_0000);
		add_reg(ppf_pkg::CFG_TRACKER_C, 32'h0000_8000);
		add_reg(ppf_pkg::CFG_TRACKER_ENABLE, 32'd7);
		add_word(pkt_w(ppf_pkg::OP_PACKET, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_0000, 1'b0, 1'b0));
		add_word(pkt_w(ppf_pkg::OP_PACKET, 1'b1, 32'hFFFF_FFFE, 32'h0000_FFFF, 1'b0, 1'b0));
		add_word(pkt_w(ppf_pkg::OP_PACKET, 1'b1, 32'hFFFF_FFFF, 32'h8000_1234, 1'b0, 1'b0));
		add_reg(ppf_pkg::CFG_TRACKER_ENABLE, 32'd5);
		add_word(pkt_w(ppf_pkg::OP_PACKET, 1'b1, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed plan
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				if (!cfg_open)
					drain_results();
				set_reg(plan[i].reg_idx, plan[i].reg_val);
				cfg_open = 1'b1;
			end else begin
				if (cfg_open)
					cfg_we <= 1'b0;
				cfg_open = 1'b0;
				send_word(plan[i].word, plan[i].typed, plan[i].result);
			end
		end

		// Random phases, each with fresh register settings
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			case ($urandom_range(0, 4))
				0: set_reg(ppf_pkg::CFG_APP_UID_MIN, 32'd0);
				1: set_reg(ppf_pkg::CFG_APP_UID_MIN, 32'hFFFF_FFFF);
				2: set_reg(ppf_pkg::CFG_APP_UID_MIN, ppf_pkg::APP_UID_MIN_RST);
				3: set_reg(ppf_pkg::CFG_APP_UID_MIN, $urandom);
				default: set_reg(ppf_pkg::CFG_APP_UID_MIN, $urandom_range(0, 20000));
			endcase
			set_reg(ppf_pkg::CFG_TRACKER_A,
				(ph % 3 == 0) ? 32'(ppf_pkg::TRACKER_A_RST) : $urandom);
			set_reg(ppf_pkg::CFG_TRACKER_B, (ph % 3 == 1) ? 32'h0000_FFFF : $urandom);
			set_reg(ppf_pkg::CFG_TRACKER_C, (ph % 3 == 2) ? 32'h0 : $urandom);
			set_reg(ppf_pkg::CFG_TRACKER_ENABLE, $urandom_range(0, 7));
			cfg_we <= 1'b0;
			// one phase runs with no idling on either side
			calm = (ph == 3);
			for (int k = 0; k < PHASE_WORDS; k++)
				send_word(random_word(), 1'b0, '0);
		end

		drain_results();
		calm = 1'b0;
		repeat (2 * (ppf_pkg::RULE_ENTRIES + 1)) @(posedge clk);
		if (pending_results.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, pending_results.size());
		end

		$display("Checked %0d packets (%0d dropped, %0d tracker hits) and %0d rule words",
			n_packets, n_drops, n_trk, n_rules);
		$display("%0d rule words refused on a full table, %0d register phases, %0d errors",
			n_full, PHASES, errors);
		if (errors == 0)
			$display("per_user_packet_filter test passed");
		else
			$display("per_user_packet_filter test failed");
		$finish;
	end

endmodule
